// ----- rtl/core/jvm_pkg.sv -----
// Package for the integer bytecode execute unit: opcodes, status codes,
// controller states and the command/status structs. No dependencies.
package jvm_pkg;

  localparam int STACK_DEPTH  = 16;
  localparam int LOCALS_DEPTH = 16;
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int LV_W  = $clog2(LOCALS_DEPTH);
  localparam int LIM_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_STACK_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCALS_LIMIT = 1'd1;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RET   = 3'd1,
    ST_NI    = 3'd2,
    ST_DIV0  = 3'd3,
    ST_STACK = 3'd4,
    ST_LOCAL = 3'd5
  } status_t;

  localparam logic [7:0] OP_NOP       = 8'h00;
  localparam logic [7:0] OP_CONST_M1  = 8'h02;
  localparam logic [7:0] OP_CONST_5   = 8'h08;
  localparam logic [7:0] OP_PUSH_BYTE = 8'h10;
  localparam logic [7:0] OP_SIPUSH    = 8'h11;
  localparam logic [7:0] OP_LDC       = 8'h12;
  localparam logic [7:0] OP_LOAD      = 8'h15;
  localparam logic [7:0] OP_LOAD_0    = 8'h1A;
  localparam logic [7:0] OP_LOAD_3    = 8'h1D;
  localparam logic [7:0] OP_STORE     = 8'h36;
  localparam logic [7:0] OP_STORE_0   = 8'h3B;
  localparam logic [7:0] OP_STORE_3   = 8'h3E;
  localparam logic [7:0] OP_IADD      = 8'h60;
  localparam logic [7:0] OP_IMUL      = 8'h68;
  localparam logic [7:0] OP_IDIV      = 8'h6C;
  localparam logic [7:0] OP_IINC      = 8'h84;
  localparam logic [7:0] OP_IFCMPGE   = 8'hA2;
  localparam logic [7:0] OP_GOTO      = 8'hA7;
  localparam logic [7:0] OP_RETURN    = 8'hAC;
  localparam logic [7:0] OP_ARG       = 8'hFE;
  localparam logic [7:0] OP_FRAME     = 8'hFF;

  // result select for the value written back
  typedef enum logic [2:0] {
    K_NONE, K_PUSH, K_STORE, K_ADD, K_MUL, K_DIV, K_CMPGE, K_IINC
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT
  } state_t;

  typedef struct packed {
    logic latch;      // capture item, start operand reads
    logic exec;       // operands are valid: check and commit
    logic div_start;
    logic out_load;   // result register loads
  } cmd_t;

  typedef struct packed {
    logic need_div;   // checks passed and op is idiv
    logic div_done;
  } stat_t;

endpackage

// ----- rtl/core/jvm_int_stack_execute_unit.sv -----
// Top level of the integer bytecode execute unit.
// Depends on jvm_pkg, jvm_ctrl, jvm_datapath (and jvm_div below it).
//
//  channel  | direction | payload
//  in_      | sink      | tdata = cmd[7:0], local_index[15:8], imm[47:16]
//  out_     | source    | tdata = status[2:0], pc_step[18:3], ret_value[50:19]
//  cfg_     | sink      | index 0 stack_limit, 1 locals_limit
//
// Each item passes capture, operand read and execute; idiv adds the 32
// steps of the bit-serial divider and its registered done flag. One item in
// flight; the next is taken once the result sits in the output register, and
// execute waits only while that register is still full. Reset empties the
// stack pointer and loads both limits with 16; stack and local contents are
// not cleared.
module jvm_int_stack_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cmd, local_index, imm
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status, pc_step, ret_value, zero pad
  input  logic        cfg_we,
  input  logic [jvm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jvm_pkg::LIM_W-1:0]     cfg_wdata
);
  jvm_pkg::cmd_t  cmd;
  jvm_pkg::stat_t stat;
  logic [2:0]  res_status;
  logic [15:0] res_step;
  logic [31:0] res_ret;

  jvm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .stat(stat)
  );

  jvm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_op(in_tdata[7:0]), .in_idx(in_tdata[15:8]), .in_imm(in_tdata[47:16]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_val(cfg_wdata),
    .res_status(res_status), .res_step(res_step), .res_ret(res_ret)
  );

  assign out_tdata = {5'd0, res_ret, res_step, res_status};
endmodule

// ----- rtl/core/jvm_div.sv -----
// Iterative 32-bit signed divider, one quotient bit a cycle.
// No dependencies.
module jvm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] q
);
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] ma, mb;

  assign ma = a[31] ? (32'd0 - a) : a;
  assign mb = b[31] ? (32'd0 - b) : b;
  assign trial = {rem_r, quo_r[31]} - {1'b0, dvs_r};

  always_comb begin
    rem_nxt = rem_r; quo_nxt = quo_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; neg_nxt = neg_r; done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0; quo_nxt = ma; dvs_nxt = mb; cnt_nxt = 6'd32;
      busy_nxt = 1'b1; neg_nxt = a[31] ^ b[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt; quo_r <= quo_nxt; dvs_r <= dvs_nxt; neg_r <= neg_nxt;
  end

  // min / -1 falls out naturally: magnitude 2^31 negated back to itself
  assign done = done_r;
  assign q    = neg_r ? (32'd0 - quo_r) : quo_r;
endmodule

// ----- rtl/core/jvm_datapath.sv -----
// Datapath: item capture, operand stack and locals memories, decode, checks,
// ALU and result register. Depends on jvm_pkg and jvm_div.
module jvm_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  jvm_pkg::cmd_t         cmd,
  output jvm_pkg::stat_t        stat,
  input  logic [7:0]            in_op,
  input  logic [7:0]            in_idx,
  input  logic [31:0]           in_imm,
  input  logic                  cfg_we,
  input  logic [jvm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [jvm_pkg::LIM_W-1:0]     cfg_val,
  output logic [2:0]            res_status,
  output logic [15:0]           res_step,
  output logic [31:0]           res_ret
);
  localparam int SPW = jvm_pkg::SP_W;
  localparam int LVW = jvm_pkg::LV_W;

  logic [31:0] stk_mem [jvm_pkg::STACK_DEPTH];
  logic [31:0] lv_mem  [jvm_pkg::LOCALS_DEPTH];

  logic [7:0]  op_r, idx_r;
  logic [31:0] imm_r;
  logic [SPW:0] sp_r, sp_nxt;
  logic [jvm_pkg::LIM_W-1:0] slim_r, llim_r;
  logic [31:0] top_r, sec_r, lv_rd_r;
  logic [31:0] mul_r;
  logic        div_pend_r;

  // decode of the captured item
  jvm_pkg::kind_t kind;
  logic        push, is_load, uses_local, frame, arg, ni;
  logic [1:0]  pops;
  logic [15:0] len;
  logic [31:0] pval;
  logic [7:0]  eidx;

  always_comb begin
    kind = jvm_pkg::K_NONE; push = 1'b0; is_load = 1'b0; pops = 2'd0;
    len = 16'd1; pval = imm_r; eidx = idx_r; ni = 1'b0;
    frame = (op_r == jvm_pkg::OP_FRAME); arg = (op_r == jvm_pkg::OP_ARG);
    if (op_r == jvm_pkg::OP_NOP || frame || arg) begin
    end else if (op_r >= jvm_pkg::OP_CONST_M1 && op_r <= jvm_pkg::OP_CONST_5) begin
      push = 1'b1; pval = {24'd0, op_r} - 32'd3;
    end else if (op_r == jvm_pkg::OP_PUSH_BYTE) begin
      push = 1'b1; pval = {{24{imm_r[7]}}, imm_r[7:0]}; len = 16'd2;
    end else if (op_r == jvm_pkg::OP_SIPUSH) begin
      push = 1'b1; pval = {{16{imm_r[15]}}, imm_r[15:0]}; len = 16'd3;
    end else if (op_r == jvm_pkg::OP_LDC) begin
      push = 1'b1; len = 16'd2;
    end else if (op_r == jvm_pkg::OP_LOAD) begin
      push = 1'b1; is_load = 1'b1; len = 16'd2;
    end else if (op_r >= jvm_pkg::OP_LOAD_0 && op_r <= jvm_pkg::OP_LOAD_3) begin
      push = 1'b1; is_load = 1'b1; eidx = op_r - jvm_pkg::OP_LOAD_0;
    end else if (op_r == jvm_pkg::OP_STORE) begin
      kind = jvm_pkg::K_STORE; pops = 2'd1; len = 16'd2;
    end else if (op_r >= jvm_pkg::OP_STORE_0 && op_r <= jvm_pkg::OP_STORE_3) begin
      kind = jvm_pkg::K_STORE; pops = 2'd1; eidx = op_r - jvm_pkg::OP_STORE_0;
    end else if (op_r == jvm_pkg::OP_IADD) begin
      kind = jvm_pkg::K_ADD; pops = 2'd2;
    end else if (op_r == jvm_pkg::OP_IMUL) begin
      kind = jvm_pkg::K_MUL; pops = 2'd2;
    end else if (op_r == jvm_pkg::OP_IDIV) begin
      kind = jvm_pkg::K_DIV; pops = 2'd2;
    end else if (op_r == jvm_pkg::OP_IINC) begin
      kind = jvm_pkg::K_IINC; len = 16'd3;
    end else if (op_r == jvm_pkg::OP_IFCMPGE) begin
      kind = jvm_pkg::K_CMPGE; pops = 2'd2; len = 16'd3;
    end else if (op_r == jvm_pkg::OP_GOTO) begin
    end else if (op_r == jvm_pkg::OP_RETURN) begin
      pops = 2'd1;
    end else begin
      ni = 1'b1;
    end
    if (push) kind = jvm_pkg::K_PUSH;
    uses_local = is_load || kind == jvm_pkg::K_STORE || kind == jvm_pkg::K_IINC;
  end

  // capped limits
  logic [SPW:0] scap;
  logic [8:0]   lcap;
  assign scap = (slim_r > jvm_pkg::LIM_W'(jvm_pkg::STACK_DEPTH)) ?
                (SPW+1)'(jvm_pkg::STACK_DEPTH) : (SPW+1)'(slim_r);
  assign lcap = (llim_r > jvm_pkg::LIM_W'(jvm_pkg::LOCALS_DEPTH)) ?
                9'(jvm_pkg::LOCALS_DEPTH) : 9'(llim_r);

  jvm_pkg::status_t chk;
  always_comb begin
    chk = jvm_pkg::ST_OK;
    if (frame) chk = jvm_pkg::ST_OK;
    else if (arg) begin
      if ({1'b0, idx_r} >= lcap) chk = jvm_pkg::ST_LOCAL;
    end else if (ni) chk = jvm_pkg::ST_NI;
    else if (uses_local && {1'b0, eidx} >= lcap) chk = jvm_pkg::ST_LOCAL;
    else if (sp_r < (SPW+1)'(pops)) chk = jvm_pkg::ST_STACK;
    else if (push && sp_r >= scap) chk = jvm_pkg::ST_STACK;
    else if (kind == jvm_pkg::K_DIV && top_r == 32'd0) chk = jvm_pkg::ST_DIV0;
  end

  // stack read addresses; memories are read in the cycle after capture
  logic [SPW-1:0] a_top, a_sec, a_push;
  logic [SPW:0]   sp_m1, sp_m2;
  assign sp_m1  = sp_r - (SPW+1)'(1);
  assign sp_m2  = sp_r - (SPW+1)'(2);
  assign a_top  = sp_m1[SPW-1:0];
  assign a_sec  = sp_m2[SPW-1:0];
  assign a_push = sp_r[SPW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_op; idx_r <= in_idx; imm_r <= in_imm;
    end
    top_r   <= stk_mem[a_top];
    sec_r   <= stk_mem[a_sec];
    lv_rd_r <= lv_mem[eidx[LVW-1:0]];
  end

  // multiplier registered ahead of commit; div through the jvm_div unit
  logic        div_done;
  logic [31:0] div_q;
  jvm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .a(sec_r), .b(top_r), .done(div_done), .q(div_q)
  );
  always_ff @(posedge clk) mul_r <= sec_r * top_r;

  logic ok;
  logic ge;
  assign ok = (chk == jvm_pkg::ST_OK);
  assign ge = $signed(sec_r) >= $signed(top_r);

  assign stat.need_div = ok && kind == jvm_pkg::K_DIV;
  assign stat.div_done = div_done;

  // commit: exec for everything but an idiv that passed its checks, div_done for that idiv
  logic commit;
  assign commit = (cmd.exec && !(ok && kind == jvm_pkg::K_DIV)) || div_done;

  logic        swe, lwe;
  logic [SPW-1:0] swa;
  logic [31:0] swd, lwd;
  logic [LVW-1:0] lwa;

  always_comb begin
    swe = 1'b0; swa = a_sec; swd = 32'd0; lwe = 1'b0; lwa = eidx[LVW-1:0];
    lwd = top_r; sp_nxt = sp_r;
    if (commit) begin
      if (frame) sp_nxt = '0;
      else if (arg) begin
        if (ok) begin lwe = 1'b1; lwa = idx_r[LVW-1:0]; lwd = imm_r; end
      end else if (ok || div_done) begin
        unique case (kind)
          jvm_pkg::K_PUSH: begin
            swe = 1'b1; swa = a_push; swd = is_load ? lv_rd_r : pval;
            sp_nxt = sp_r + (SPW+1)'(1);
          end
          jvm_pkg::K_STORE: begin lwe = 1'b1; sp_nxt = sp_m1; end
          jvm_pkg::K_ADD: begin swe = 1'b1; swd = sec_r + top_r; sp_nxt = sp_m1; end
          jvm_pkg::K_MUL: begin swe = 1'b1; swd = mul_r; sp_nxt = sp_m1; end
          jvm_pkg::K_DIV: begin swe = 1'b1; swd = div_q; sp_nxt = sp_m1; end
          jvm_pkg::K_CMPGE: sp_nxt = sp_m2;
          jvm_pkg::K_IINC: begin
            lwe = 1'b1; lwd = lv_rd_r + {{24{imm_r[7]}}, imm_r[7:0]};
          end
          default: if (op_r == jvm_pkg::OP_RETURN) sp_nxt = sp_m1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (swe) stk_mem[swa] <= swd;
    if (lwe) lv_mem[lwa] <= lwd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0; slim_r <= 5'd16; llim_r <= 5'd16; div_pend_r <= 1'b0;
    end else begin
      sp_r <= sp_nxt;
      div_pend_r <= cmd.div_start ? 1'b1 : (div_done ? 1'b0 : div_pend_r);
      if (cfg_we && cfg_idx == jvm_pkg::CFG_STACK_LIMIT)  slim_r <= cfg_val;
      if (cfg_we && cfg_idx == jvm_pkg::CFG_LOCALS_LIMIT) llim_r <= cfg_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (commit && cmd.out_load) begin
      if (div_done) begin
        res_status <= jvm_pkg::ST_OK; res_step <= 16'd1; res_ret <= 32'd0;
      end else if (frame || arg || !ok) begin
        res_status <= chk; res_step <= 16'd0; res_ret <= 32'd0;
      end else if (op_r == jvm_pkg::OP_RETURN) begin
        res_status <= jvm_pkg::ST_RET; res_step <= 16'd0; res_ret <= top_r;
      end else begin
        res_status <= jvm_pkg::ST_OK; res_ret <= 32'd0;
        if (op_r == jvm_pkg::OP_GOTO || (kind == jvm_pkg::K_CMPGE && ge))
          res_step <= imm_r[15:0];
        else res_step <= len;
      end
    end
  end

  ap_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= (SPW+1)'(jvm_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");
  ap_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_pend_r)
    else $error("divider restarted while busy");
  ap_sp_still: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> sp_r == $past(sp_r))
    else $error("stack pointer moved without commit");
endmodule

// ----- rtl/core/jvm_ctrl.sv -----
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on jvm_pkg.
module jvm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output jvm_pkg::cmd_t  cmd,
  input  jvm_pkg::stat_t stat
);
  jvm_pkg::state_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jvm_pkg::S_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; cmd = '0; ov_nxt = ov_r; in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      jvm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin cmd.latch = 1'b1; state_nxt = jvm_pkg::S_READ; end
      end
      jvm_pkg::S_READ: state_nxt = jvm_pkg::S_EXEC;
      jvm_pkg::S_EXEC: begin
        // result register must be free before any commit
        if (!ov_r || out_ready) begin
          if (stat.need_div) begin
            cmd.exec = 1'b1; cmd.div_start = 1'b1; state_nxt = jvm_pkg::S_DIV;
          end else begin
            cmd.exec = 1'b1; cmd.out_load = 1'b1; ov_nxt = 1'b1;
            state_nxt = jvm_pkg::S_IDLE;
          end
        end
      end
      jvm_pkg::S_DIV: begin
        if (stat.div_done) begin
          cmd.out_load = 1'b1; ov_nxt = 1'b1; state_nxt = jvm_pkg::S_IDLE;
        end
      end
      default: state_nxt = jvm_pkg::S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  ap_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == jvm_pkg::S_DIV && stat.div_done |-> !ov_r)
    else $error("result overwritten by divide");
  ap_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && !stat.div_done |-> !ov_r || out_ready)
    else $error("result overwritten");
  ap_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == jvm_pkg::S_READ)
    else $error("capture not followed by read");
endmodule
